// ----- src/mlr_pkg.sv -----
// shared types and constants of the midpoint line rasterizer
package mlr_pkg;

    localparam int COORD_BITS    = 10;
    localparam int DEC_BITS      = COORD_BITS + 4;
    localparam int CMDQ_DEPTH    = 2;
    localparam int CMDQ_PTR_BITS = $clog2(CMDQ_DEPTH);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic signed [DEC_BITS-1:0] t_dec;

    // classified item handed from the front to the walker
    typedef struct packed {
        logic   is_load;
        t_coord x1;
        t_coord y1;
        t_coord major_end;
        t_dec   decision;
        t_dec   inc_no_step;
        t_dec   inc_with_step;
        logic   steep;
        logic   minor_down;
    } t_cmd;

endpackage

// ----- src/midpoint_line_rasterizer_top.sv -----
// top level of the midpoint line rasterizer
// input channel: push/full; an item is taken when push is high and full is low.
//   mode 0 loads a line from the two endpoints and gives no result,
//   mode 1 asks for the next pixel of the active line.
// result channel: empty/pop; pixel_x, pixel_y and last are valid while empty
//   is low, and the item leaves when pop is high.
// a step item passes the front register, the command queue and the walker
//   output register before its pixel shows.
// throughput: one item per cycle on both sides unless the receiver stalls;
//   every step is one add and compare in the walker; a load gives no pixel.
// a step with no active line, or after the last pixel, is dropped silently.
// reset empties the front register, the two-entry command queue and the
//   output register, and leaves no line active.
// when the receiver stalls, the output register holds its pixel, the walker
//   waits on the next step, the command queue fills, and full rises once the
//   front register holds a third waiting item.
module midpoint_line_rasterizer_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic            i_mode,
    input  mlr_pkg::t_coord i_x_start,
    input  mlr_pkg::t_coord i_y_start,
    input  mlr_pkg::t_coord i_x_end,
    input  mlr_pkg::t_coord i_y_end,
    output logic            empty,
    input  logic            pop,
    output mlr_pkg::t_coord o_pixel_x,
    output mlr_pkg::t_coord o_pixel_y,
    output logic            o_last
);
    import mlr_pkg::*;

    logic cmd_wr;
    logic cmd_full;
    logic cmd_rd;
    logic cmd_empty;
    t_cmd cmd_in;
    t_cmd cmd_out;

    mlr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_mode     (i_mode),
        .i_x_start  (i_x_start),
        .i_y_start  (i_y_start),
        .i_x_end    (i_x_end),
        .i_y_end    (i_y_end),
        .o_cmd_wr   (cmd_wr),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    mlr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_rd    (cmd_rd),
        .o_empty (cmd_empty),
        .o_data  (cmd_out)
    );

    mlr_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_rd    (cmd_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last      (o_last)
    );

endmodule

// ----- src/mlr_front.sv -----
// front stage: takes items, works out the line setup for loads
module mlr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic          i_mode,
    input  mlr_pkg::t_coord i_x_start,
    input  mlr_pkg::t_coord i_y_start,
    input  mlr_pkg::t_coord i_x_end,
    input  mlr_pkg::t_coord i_y_end,
    output logic          o_cmd_wr,
    output mlr_pkg::t_cmd o_cmd,
    input  logic          i_cmd_full
);
    import mlr_pkg::*;

    logic   r_vld;
    logic   r_mode;
    t_coord r_x1;
    t_coord r_y1;
    t_coord r_x2;
    t_coord r_y2;

    logic   take;
    logic   steep;
    logic   swap;
    logic   minor_down;
    t_coord sx1;
    t_coord sy1;
    t_coord sx2;
    t_coord sy2;
    t_dec   a0;
    t_dec   b0;
    t_dec   mag_a;
    t_dec   mag_b;
    t_dec   a;
    t_dec   b;
    t_dec   p;
    t_dec   q;
    t_dec   qq;

    assign o_cmd_wr = r_vld && !i_cmd_full;
    assign o_full   = r_vld && i_cmd_full;
    assign take     = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (o_cmd_wr) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mode <= i_mode;
            r_x1   <= i_x_start;
            r_y1   <= i_y_start;
            r_x2   <= i_x_end;
            r_y2   <= i_y_end;
        end
    end

    always_comb begin
        a0    = t_dec'(r_y1) - t_dec'(r_y2);
        b0    = t_dec'(r_x2) - t_dec'(r_x1);
        mag_a = a0[DEC_BITS-1] ? -a0 : a0;
        mag_b = b0[DEC_BITS-1] ? -b0 : b0;
        // equal magnitudes count as shallow
        steep = mag_a > mag_b;
        swap  = steep ? (r_y1 > r_y2) : (r_x1 > r_x2);
        sx1   = swap ? r_x2 : r_x1;
        sy1   = swap ? r_y2 : r_y1;
        sx2   = swap ? r_x1 : r_x2;
        sy2   = swap ? r_y1 : r_y2;
        a     = t_dec'(sy1) - t_dec'(sy2);
        b     = t_dec'(sx2) - t_dec'(sx1);
        minor_down = steep ? (sx1 > sx2) : (sy1 > sy2);
        // p drives the no-step increment, q the minor-axis term
        p     = steep ? b : a;
        q     = steep ? a : b;
        qq    = minor_down ? -q : q;

        o_cmd.is_load       = (r_mode == MODE_LOAD);
        o_cmd.x1            = sx1;
        o_cmd.y1            = sy1;
        o_cmd.major_end     = steep ? sy2 : sx2;
        o_cmd.decision      = (p <<< 1) + qq;
        o_cmd.inc_no_step   = p <<< 1;
        o_cmd.inc_with_step = (p + qq) <<< 1;
        o_cmd.steep         = steep;
        o_cmd.minor_down    = minor_down;
    end

endmodule

// ----- src/mlr_cmd_fifo.sv -----
// short queue of classified items between the front and the walker
module mlr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  mlr_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_empty,
    output mlr_pkg::t_cmd o_data
);
    import mlr_pkg::*;

    t_cmd                     r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_BITS-1:0] r_wptr;
    logic [CMDQ_PTR_BITS-1:0] r_rptr;
    logic [CMDQ_PTR_BITS:0]   r_cnt;
    logic                     do_wr;
    logic                     do_rd;

    assign o_full  = (r_cnt == (CMDQ_PTR_BITS+1)'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- src/mlr_walker.sv -----
// back stage: holds the line state, walks one pixel per step item while a line is active
module mlr_walker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_empty,
    input  mlr_pkg::t_cmd   i_cmd,
    output logic            o_cmd_rd,
    output logic            o_empty,
    input  logic            i_pop,
    output mlr_pkg::t_coord o_pixel_x,
    output mlr_pkg::t_coord o_pixel_y,
    output logic            o_last
);
    import mlr_pkg::*;

    t_coord r_cur_x;
    t_coord r_cur_y;
    t_coord r_major_end;
    t_dec   r_dec;
    t_dec   r_inc_no;
    t_dec   r_inc_with;
    logic   r_steep;
    logic   r_minor_down;
    logic   r_active;
    logic   r_out_vld;
    t_coord r_out_x;
    t_coord r_out_y;
    logic   r_out_last;

    logic   out_free;
    logic   emit;
    logic   is_last;
    logic   dec_pos;
    logic   move_minor;
    t_coord minor_cur;
    t_coord n_minor;
    t_coord n_major;

    assign out_free = !r_out_vld || i_pop;
    // a step with no active line is dropped without needing output space
    assign o_cmd_rd = !i_cmd_empty && (i_cmd.is_load || !r_active || out_free);
    assign emit     = o_cmd_rd && !i_cmd.is_load && r_active;

    assign o_empty   = !r_out_vld;
    assign o_pixel_x = r_out_x;
    assign o_pixel_y = r_out_y;
    assign o_last    = r_out_last;

    always_comb begin
        is_last   = ((r_steep ? r_cur_y : r_cur_x) == r_major_end);
        dec_pos   = !r_dec[DEC_BITS-1] && (r_dec != '0);
        // steep rising and shallow falling step on a positive decision
        move_minor = (r_steep ^ r_minor_down) ? dec_pos : r_dec[DEC_BITS-1];
        minor_cur = r_steep ? r_cur_x : r_cur_y;
        if (move_minor) begin
            n_minor = r_minor_down ? minor_cur - COORD_BITS'(1) : minor_cur + COORD_BITS'(1);
        end else begin
            n_minor = minor_cur;
        end
        n_major = (r_steep ? r_cur_y : r_cur_x) + COORD_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_major_end  <= '0;
            r_dec        <= '0;
            r_inc_no     <= '0;
            r_inc_with   <= '0;
            r_steep      <= 1'b0;
            r_minor_down <= 1'b0;
            r_active     <= 1'b0;
        end else if (o_cmd_rd && i_cmd.is_load) begin
            r_cur_x      <= i_cmd.x1;
            r_cur_y      <= i_cmd.y1;
            r_major_end  <= i_cmd.major_end;
            r_dec        <= i_cmd.decision;
            r_inc_no     <= i_cmd.inc_no_step;
            r_inc_with   <= i_cmd.inc_with_step;
            r_steep      <= i_cmd.steep;
            r_minor_down <= i_cmd.minor_down;
            r_active     <= 1'b1;
        end else if (emit) begin
            if (is_last) begin
                r_active <= 1'b0;
            end else begin
                r_dec   <= r_dec + (move_minor ? r_inc_with : r_inc_no);
                r_cur_x <= r_steep ? n_minor : n_major;
                r_cur_y <= r_steep ? n_major : n_minor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (i_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x    <= r_cur_x;
            r_out_y    <= r_cur_y;
            r_out_last <= is_last;
        end
    end

endmodule
